/* hdl/cglm_pkg.sv */
// Shared types, codes and tables of the context-gated logistic mixer.
package cglm_pkg;

  localparam int DEF_MAIN_INPUTS  = 32;
  localparam int DEF_EXTRA_INPUTS = 8;
  localparam int DEF_CONTEXTS     = 1024;

  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_MIX      = 2'd1;
  localparam logic [1:0] CMD_PERCEIVE = 2'd2;

  localparam logic [2:0] REG_LEARNING_RATE  = 3'd0;
  localparam logic [2:0] REG_INITIAL_WEIGHT = 3'd1;
  localparam logic [2:0] REG_MAIN_USED      = 3'd2;
  localparam logic [2:0] REG_EXTRA_USED     = 3'd3;
  localparam logic [2:0] REG_CONTEXT_LIMIT  = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef struct packed {
    logic [1:0]         command;
    logic [5:0]         element_index;
    logic signed [15:0] element_value;
    logic [63:0]        context_key;
    logic               coded_bit;
  } in_t;

  typedef struct packed {
    logic signed [23:0] mixed_value;
    logic               used_overflow_slot;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_SRD, OP_SCMP, OP_ALLOC, OP_MRD, OP_MMUL, OP_MACC, OP_MFIN,
    OP_PRD, OP_PPREP, OP_PWAIT, OP_PG, OP_PR, OP_PU, OP_WRD, OP_WM1, OP_WS1, OP_WS2
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic srch_end;
    logic hit;
    logic walk_last;
    logic div_done;
    logic selected;
  } dp_stat_t;

  function automatic logic [11:0] squash_lut(input logic [5:0] k);
    logic [11:0] v;
    case (k)
      6'd0: v = 12'd1;     6'd1: v = 12'd2;     6'd2: v = 12'd3;     6'd3: v = 12'd6;
      6'd4: v = 12'd10;    6'd5: v = 12'd16;    6'd6: v = 12'd27;    6'd7: v = 12'd45;
      6'd8: v = 12'd73;    6'd9: v = 12'd120;   6'd10: v = 12'd194;  6'd11: v = 12'd310;
      6'd12: v = 12'd488;  6'd13: v = 12'd747;  6'd14: v = 12'd1101; 6'd15: v = 12'd1546;
      6'd16: v = 12'd2047; 6'd17: v = 12'd2549; 6'd18: v = 12'd2994; 6'd19: v = 12'd3348;
      6'd20: v = 12'd3607; 6'd21: v = 12'd3785; 6'd22: v = 12'd3901; 6'd23: v = 12'd3975;
      6'd24: v = 12'd4024; 6'd25: v = 12'd4050; 6'd26: v = 12'd4068; 6'd27: v = 12'd4079;
      6'd28: v = 12'd4085; 6'd29: v = 12'd4089; 6'd30: v = 12'd4092; 6'd31: v = 12'd4093;
      default: v = 12'd4094;
    endcase
    return v;
  endfunction

  // 0.9/(1e-7*s+0.8)^0.8 in Q1.16 at s = k*2^24
  function automatic logic [16:0] decay_lut(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0: v = 17'd70510;  5'd1: v = 17'd28542;  5'd2: v = 17'd18873;  5'd3: v = 17'd14388;
      5'd4: v = 17'd11753;  5'd5: v = 17'd10003;  5'd6: v = 17'd8747;   5'd7: v = 17'd7798;
      5'd8: v = 17'd7053;   5'd9: v = 17'd6451;   5'd10: v = 17'd5953;  5'd11: v = 17'd5535;
      5'd12: v = 17'd5177;  5'd13: v = 17'd4867;  5'd14: v = 17'd4596;  5'd15: v = 17'd4357;
      default: v = 17'd4144;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -34'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

endpackage

/* hdl/context_gated_logistic_mixer.sv */
// Load: never busy. Mix: a key read and a compare state per stored key compared, an
// allocate state when no key matched, then read, multiply and accumulate states per input
// element through the single MAC, and a finish state from which the result strobe is registered.
// Perceive: the iterative divider, then read, multiply, shrink and write-back states per weight.
// One request at a time; out_valid pulses one cycle and cannot be stalled.
// Synchronous active-low reset clears control state; stores need no clearing pass.
module context_gated_logistic_mixer #(
  parameter int MAIN_INPUTS  = cglm_pkg::DEF_MAIN_INPUTS,
  parameter int EXTRA_INPUTS = cglm_pkg::DEF_EXTRA_INPUTS,
  parameter int CONTEXTS     = cglm_pkg::DEF_CONTEXTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  cglm_pkg::in_t                   in_data,
  output logic                            out_valid,
  output cglm_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [cglm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cglm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cglm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     accept;

  assign accept = start && !busy;

  cglm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .command (in_data.command),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  cglm_dpath #(
    .MAIN_IN  (MAIN_INPUTS),
    .EXTRA_IN (EXTRA_INPUTS),
    .CTX      (CONTEXTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* hdl/cglm_div.sv */
// Iterative restoring divider for the per-context step ratio, clamped to 1.5 in Q1.16.
module cglm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [16:0] quo
);
  import cglm_pkg::*;

  localparam logic [16:0] QCAP = 17'd98304;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [16:0] q_r, q_nxt;
  logic [31:0] den_r, den_nxt;
  logic        c0_r, c0_nxt;
  logic [32:0] trial;
  logic        qbit;
  logic [16:0] qn;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    c0_nxt   = c0_r;
    trial    = {rem_r[31:0], (cnt_r == 5'd16) ? c0_r : 1'b0};
    qbit     = trial >= {1'b0, den_r};
    qn       = {q_r[15:0], qbit};
    if (start) begin
      den_nxt = den;
      c0_nxt  = num[0];
      q_nxt   = 17'd0;
      // ratio already at or above 2.0: clamp right away
      if ({1'b0, num} >= {den, 1'b0}) begin
        q_nxt    = QCAP;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        rem_nxt  = {2'b00, num[31:1]};
        cnt_nxt  = 5'd16;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = qbit ? (trial - {1'b0, den_r}) : trial;
      q_nxt   = qn;
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        q_nxt    = (qn > QCAP) ? QCAP : qn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    c0_r  <= c0_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

/* hdl/cglm_dpath.sv */
// Datapath: configuration, input/key/weight/step stores, MAC and weight update arithmetic.
module cglm_dpath #(
  parameter int MAIN_IN  = cglm_pkg::DEF_MAIN_INPUTS,
  parameter int EXTRA_IN = cglm_pkg::DEF_EXTRA_INPUTS,
  parameter int CTX      = cglm_pkg::DEF_CONTEXTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  cglm_pkg::in_t                 in_data,
  input  logic                          cfg_we,
  input  logic [cglm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cglm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  cglm_pkg::dp_cmd_t             cmd,
  output cglm_pkg::dp_stat_t            stat,
  output logic                          out_valid,
  output cglm_pkg::out_t                out_data
);
  import cglm_pkg::*;

  localparam int ALL_IN = MAIN_IN + EXTRA_IN;
  localparam int EL_W   = (ALL_IN > 1) ? $clog2(ALL_IN) : 1;
  localparam int SLOT_W = $clog2(CTX + 1);
  localparam int KA_W   = (CTX > 1) ? $clog2(CTX) : 1;
  localparam int WA_W   = $clog2((CTX + 1) * ALL_IN);
  localparam int SN_D   = (EXTRA_IN > 0) ? EXTRA_IN : 1;
  localparam int SN_W   = (SN_D > 1) ? $clog2(SN_D) : 1;
  localparam int ACC_W  = 49 + EL_W;
  localparam logic signed [ACC_W:0] RND_HALF = (ACC_W+1)'(524288);
  localparam logic signed [ACC_W:0] MIX_MAX  = (ACC_W+1)'(8388607);
  localparam logic signed [ACC_W:0] MIX_MIN  = (ACC_W+1)'(-8388608);

  // configuration
  logic [15:0]        lr_r;
  logic signed [31:0] initw_r;
  logic [5:0]         mused_r;
  logic [3:0]         eused_r;
  logic [10:0]        climit_r;

  // stores
  logic signed [15:0] in_mem [ALL_IN];
  logic               in_vld_r [ALL_IN];
  logic [63:0]        key_mem [CTX];
  logic [31:0]        step_mem [CTX+1];
  logic signed [31:0] w_mem [(CTX+1)*ALL_IN];

  logic signed [15:0] in_rd_r;
  logic               in_rdv_r;
  logic [63:0]        key_rd_r;
  logic [31:0]        step_rd_r;
  logic signed [31:0] w_rd_r;

  in_t                in_r;
  logic [SLOT_W-1:0]  idx_r, slots_r, cur_r;
  logic               ovfv_r, ovf_r, alloc_r, sel_r;
  logic [EL_W-1:0]    e_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [47:0] prod_r;
  logic signed [15:0] snap_r [SN_D];
  logic signed [23:0] last_r;
  logic               out_valid_r;
  out_t               out_r;

  logic [31:0]        c_r, max_r;
  logic [63:0]        total_r;
  logic [40:0]        dprod_r;
  logic [11:0]        sq_r;
  logic [16:0]        decay_r;
  logic signed [13:0] err_r;
  logic [33:0]        gprod_r, rprod_r;
  logic signed [31:0] u_r, w_r, v_r;
  logic signed [47:0] p1_r, p2_r;
  logic               shrink_r;

  // combinational helpers
  logic [SLOT_W-1:0]  lim;
  logic [31:0]        nm32, ne32;
  logic               is_main, used_e;
  logic [SN_W-1:0]    sidx;
  logic [WA_W-1:0]    waddr;
  logic signed [15:0] xm, xp;
  logic signed [31:0] wv;
  logic               w_we;
  logic signed [31:0] w_wd, w2, v_new;
  logic signed [32:0] ts;
  logic signed [16:0] ss;
  logic signed [ACC_W:0] rsum;
  logic signed [23:0] mix_sat;
  logic signed [15:0] dsh, dcl;
  logic [11:0]        tq;
  logic [20:0]        sq_sum;
  logic               big;
  logic [16:0]        dk, dk1;
  logic [31:0]        c1, den;
  logic               div_done;
  logic [16:0]        div_q;
  logic               hit;
  logic               ld;

  assign ld  = accept && (in_data.command == CMD_LOAD) && (32'(in_data.element_index) < ALL_IN);
  assign lim = (32'(climit_r) > CTX) ? SLOT_W'(CTX) : SLOT_W'(climit_r);
  assign nm32 = (32'(mused_r) > MAIN_IN) ? 32'(MAIN_IN) : 32'(mused_r);
  assign ne32 = (32'(eused_r) > EXTRA_IN) ? 32'(EXTRA_IN) : 32'(eused_r);
  assign is_main = 32'(e_r) < MAIN_IN;
  assign used_e  = is_main ? (32'(e_r) < nm32) : ((32'(e_r) - 32'(MAIN_IN)) < ne32);
  assign sidx    = SN_W'(32'(e_r) - 32'(MAIN_IN));
  assign waddr   = WA_W'(cur_r) * WA_W'(ALL_IN) + WA_W'(e_r);
  assign hit     = key_rd_r == in_r.context_key;

  assign xm = in_rdv_r ? in_rd_r : 16'sd0;
  assign xp = is_main ? xm : snap_r[sidx];
  assign wv = alloc_r ? initw_r : w_rd_r;

  // weight update, first step: w - round(u*x / 2^16)
  assign ts    = 33'((49'(p1_r) + 49'sd32768) >>> 16);
  assign v_new = sat34(34'(w_r) - 34'(ts));
  // shrink step: v - round(v*12885 / 2^32)
  assign ss    = 17'((49'(p2_r) + 49'sd2147483648) >>> 32);
  assign w2    = shrink_r ? sat34(34'(v_r) - 34'(ss)) : v_r;

  assign w_we = ((cmd.op == OP_MMUL) && alloc_r) || ((cmd.op == OP_WS2) && used_e);
  assign w_wd = (cmd.op == OP_MMUL) ? initw_r : w2;

  assign rsum = ((ACC_W+1)'(acc_r) + RND_HALF) >>> 20;
  assign mix_sat = (rsum > MIX_MAX) ? 24'sh7FFFFF :
                   (rsum < MIX_MIN) ? 24'sh800000 : 24'(rsum);

  // squash of the last mix output
  assign dsh = 16'(last_r >>> 8);
  assign dcl = (dsh > 16'sd2047) ? 16'sd2047 : (dsh < -16'sd2047) ? -16'sd2047 : dsh;
  assign tq  = 12'(dcl + 16'sd2048);
  assign sq_sum = 21'(squash_lut({1'b0, tq[11:7]})) * 21'(8'd128 - {1'b0, tq[6:0]})
                + 21'(squash_lut({1'b0, tq[11:7]} + 6'd1)) * 21'(tq[6:0]) + 21'd64;

  assign big = |total_r[63:28];
  assign dk  = decay_lut({1'b0, total_r[27:24]});
  assign dk1 = decay_lut({1'b0, total_r[27:24]} + 5'd1);
  assign c1  = c_r + 32'd1;
  assign den = (max_r == 32'd0) ? 32'd1 : max_r;

  cglm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_PPREP),
    .num   (step_rd_r),
    .den   (den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign stat.srch_end  = idx_r == slots_r;
  assign stat.hit       = hit;
  assign stat.walk_last = 32'(e_r) == (ALL_IN - 1);
  assign stat.div_done  = div_done;
  assign stat.selected  = sel_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r        <= 16'd131;
      initw_r     <= 32'sd0;
      mused_r     <= 6'd32;
      eused_r     <= 4'd8;
      climit_r    <= 11'd1024;
      for (int i = 0; i < ALL_IN; i++) in_vld_r[i] <= 1'b0;
      slots_r     <= '0;
      ovfv_r      <= 1'b0;
      sel_r       <= 1'b0;
      cur_r       <= '0;
      total_r     <= 64'd0;
      max_r       <= 32'd1;
      last_r      <= 24'sd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.op == OP_MFIN;
      if (cfg_we) begin
        case (cfg_index)
          REG_LEARNING_RATE:  lr_r     <= cfg_data[15:0];
          REG_INITIAL_WEIGHT: initw_r  <= $signed(cfg_data[31:0]);
          REG_MAIN_USED:      mused_r  <= cfg_data[5:0];
          REG_EXTRA_USED:     eused_r  <= cfg_data[3:0];
          REG_CONTEXT_LIMIT:  climit_r <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (ld) in_vld_r[EL_W'(in_data.element_index)] <= 1'b1;
      if (cmd.op == OP_SCMP && hit) begin
        cur_r <= idx_r;
        sel_r <= 1'b1;
      end
      if (cmd.op == OP_ALLOC) begin
        sel_r <= 1'b1;
        if (slots_r < lim) begin
          cur_r   <= slots_r;
          slots_r <= slots_r + SLOT_W'(1);
        end else begin
          cur_r  <= SLOT_W'(CTX);
          ovfv_r <= 1'b1;
        end
      end
      if (cmd.op == OP_MFIN) last_r <= mix_sat;
      if (cmd.op == OP_PU) begin
        total_r <= total_r + 64'd1;
        if (c1 > max_r) max_r <= c1;
      end
    end
  end

  // payload and stores
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r  <= in_data;
      idx_r <= '0;
    end
    if (ld) in_mem[EL_W'(in_data.element_index)] <= in_data.element_value;

    if (cmd.op == OP_SRD && idx_r != slots_r) key_rd_r <= key_mem[idx_r[KA_W-1:0]];
    if (cmd.op == OP_SCMP) begin
      if (hit) begin
        alloc_r <= 1'b0;
        ovf_r   <= 1'b0;
        e_r     <= '0;
        acc_r   <= '0;
      end else begin
        idx_r <= idx_r + SLOT_W'(1);
      end
    end
    if (cmd.op == OP_ALLOC) begin
      e_r   <= '0;
      acc_r <= '0;
      if (slots_r < lim) begin
        alloc_r <= 1'b1;
        ovf_r   <= 1'b0;
        key_mem[slots_r[KA_W-1:0]] <= in_r.context_key;
        step_mem[slots_r] <= 32'd0;
      end else begin
        alloc_r <= !ovfv_r;
        ovf_r   <= 1'b1;
        if (!ovfv_r) step_mem[SLOT_W'(CTX)] <= 32'd0;
      end
    end

    if (cmd.op == OP_MRD || cmd.op == OP_WRD) begin
      in_rd_r  <= in_mem[e_r];
      in_rdv_r <= in_vld_r[e_r];
      w_rd_r   <= w_mem[waddr];
    end
    if (w_we) w_mem[waddr] <= w_wd;

    if (cmd.op == OP_MMUL) begin
      prod_r <= xm * wv;
      if (!is_main) snap_r[sidx] <= xm;
    end
    if (cmd.op == OP_MACC) begin
      if (used_e) acc_r <= acc_r + ACC_W'(prod_r);
      if (!stat.walk_last) e_r <= e_r + EL_W'(1);
    end
    if (cmd.op == OP_MFIN) begin
      out_r.mixed_value        <= mix_sat;
      out_r.used_overflow_slot <= ovf_r;
    end

    if (cmd.op == OP_PRD) step_rd_r <= step_mem[cur_r];
    if (cmd.op == OP_PPREP) begin
      c_r     <= step_rd_r;
      dprod_r <= big ? 41'd0 : 41'(dk - dk1) * 41'(total_r[23:0]);
      sq_r    <= 12'(sq_sum >> 7);
    end
    if (cmd.op == OP_PWAIT) begin
      decay_r <= big ? decay_lut(5'd16) : 17'((({dk, 24'd0}) - dprod_r) >> 24);
      err_r   <= $signed({2'b00, sq_r}) - (in_r.coded_bit ? 14'sd4096 : 14'sd0);
    end
    if (cmd.op == OP_PG) gprod_r <= 34'(decay_r) * 34'(17'd98304 - div_q);
    if (cmd.op == OP_PR) rprod_r <= 34'(gprod_r[33:16]) * 34'(lr_r);
    if (cmd.op == OP_PU) begin
      u_r      <= $signed({14'd0, rprod_r[33:16]}) * 32'(err_r);
      step_mem[cur_r] <= c1;
      shrink_r <= c1[9:0] == 10'd0;
      e_r      <= '0;
    end
    if (cmd.op == OP_WM1) begin
      p1_r <= u_r * xp;
      w_r  <= w_rd_r;
    end
    if (cmd.op == OP_WS1) begin
      v_r  <= v_new;
      p2_r <= v_new * 16'sd12885;
    end
    if (cmd.op == OP_WS2 && !stat.walk_last) e_r <= e_r + EL_W'(1);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hdl/cglm_ctrl.sv */
// Controller: sequences key search, mix walk and perceive update over the datapath.
module cglm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         command,
  input  cglm_pkg::dp_stat_t stat,
  output logic               busy,
  output cglm_pkg::dp_cmd_t  cmd
);
  import cglm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SRCH, S_SCMP, S_ALLOC, S_MRD, S_MMUL, S_MACC, S_MFIN,
    S_PRD, S_PPREP, S_PDIV, S_PG, S_PR, S_PU, S_WRD, S_WM1, S_WS1, S_WS2
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (command == CMD_MIX) begin
            state_nxt = S_SRCH;
            op_nxt    = OP_SRD;
          end else if (command == CMD_PERCEIVE && stat.selected) begin
            state_nxt = S_PRD;
            op_nxt    = OP_PRD;
          end
        end
      end
      S_SRCH: begin
        if (stat.srch_end) begin
          state_nxt = S_ALLOC;
          op_nxt    = OP_ALLOC;
        end else begin
          state_nxt = S_SCMP;
          op_nxt    = OP_SCMP;
        end
      end
      S_SCMP: begin
        if (stat.hit) begin
          state_nxt = S_MRD;
          op_nxt    = OP_MRD;
        end else begin
          state_nxt = S_SRCH;
          op_nxt    = OP_SRD;
        end
      end
      S_ALLOC: begin
        state_nxt = S_MRD;
        op_nxt    = OP_MRD;
      end
      S_MRD: begin
        state_nxt = S_MMUL;
        op_nxt    = OP_MMUL;
      end
      S_MMUL: begin
        state_nxt = S_MACC;
        op_nxt    = OP_MACC;
      end
      S_MACC: begin
        if (stat.walk_last) begin
          state_nxt = S_MFIN;
          op_nxt    = OP_MFIN;
        end else begin
          state_nxt = S_MRD;
          op_nxt    = OP_MRD;
        end
      end
      S_MFIN: state_nxt = S_IDLE;
      S_PRD: begin
        state_nxt = S_PPREP;
        op_nxt    = OP_PPREP;
      end
      S_PPREP: begin
        state_nxt = S_PDIV;
        op_nxt    = OP_PWAIT;
      end
      S_PDIV: begin
        if (stat.div_done) begin
          state_nxt = S_PG;
          op_nxt    = OP_PG;
        end else begin
          op_nxt = OP_PWAIT;
        end
      end
      S_PG: begin
        state_nxt = S_PR;
        op_nxt    = OP_PR;
      end
      S_PR: begin
        state_nxt = S_PU;
        op_nxt    = OP_PU;
      end
      S_PU: begin
        state_nxt = S_WRD;
        op_nxt    = OP_WRD;
      end
      S_WRD: begin
        state_nxt = S_WM1;
        op_nxt    = OP_WM1;
      end
      S_WM1: begin
        state_nxt = S_WS1;
        op_nxt    = OP_WS1;
      end
      S_WS1: begin
        state_nxt = S_WS2;
        op_nxt    = OP_WS2;
      end
      S_WS2: begin
        if (!stat.walk_last) begin
          state_nxt = S_WRD;
          op_nxt    = OP_WRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_NONE;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  assign busy   = state_r != S_IDLE;
  assign cmd.op = op_r;

endmodule

/* hdl/cglm_checker.sv */
// Port-level checks of the mixer, bound to the top level.
module cglm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input cglm_pkg::in_t in_data,
  input logic          out_valid
);
  import cglm_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> (!busy && !out_valid))
    else $error("busy or result after reset");

  a_pulse: assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result shown while still busy");

  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.command == CMD_LOAD) |=> (!busy && !out_valid))
    else $error("load request made the block busy");

  a_mix_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.command == CMD_MIX) |=> (busy && !out_valid))
    else $error("mix request not taken up");

endmodule

bind context_gated_logistic_mixer cglm_checker u_cglm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid)
);
